/* rtl/ona_pkg.sv */
// Package for the object name allocator: shared constants, opcodes and scan result type.
`default_nettype none
package ona_pkg;

  localparam int NPR   = 16;
  localparam int BIT_W = 4;
  localparam int NAME_W = 10;
  localparam int CNT_W  = 5;

  typedef enum logic [1:0] {
    OP_GEN   = 2'd0,
    OP_DEL   = 2'd1,
    OP_BIND  = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } scan_res_t;

endpackage
`default_nettype wire

/* rtl/object_name_allocator.sv */
// Object name allocator top level: sequencer, row register, map RAM and output register.
//
// Keeps names 1 .. min(NAME_SPACE,1024)-1, each with a reserved and a created mark,
// stored 16 names per RAM row (reserved bits low half, created bits high half).
// Input word: in_opcode, in_name, in_count on in_valid; accepted when in_stall is low.
// One item is worked at a time; in_stall is high from acceptance until the last
// result of the item is in the output register and its map row is written back.
// Delete, bind and query: RAM read, row load, then update, write back and result;
// a name outside the space goes straight to the result without a RAM access.
// Generate: the single search unit scans one 16-name map row at a time; each row
// is read, loaded and searched, free names are handed out while the output register
// is free, the row is written back, and a status result follows when no free name is left.
// Result word: out_name, out_is_created, out_status, out_last on out_valid, taken
// when out_stall is low. A stalled result holds; the sequencer waits until the
// output register is free.
// Reset clears the sequencer state, the output valid bit and one valid bit per RAM row;
// a row never written reads as all zero, so no clearing pass is needed.
`default_nettype none
module object_name_allocator import ona_pkg::*; #(
  parameter int NAME_SPACE = 1024,
  parameter int MAX_GEN    = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        in_opcode,
  input  wire logic [NAME_W-1:0] in_name,
  input  wire logic [CNT_W-1:0]  in_count,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [NAME_W-1:0]      out_name,
  output logic                   out_is_created,
  output logic                   out_status,
  output logic                   out_last
);
  localparam int NAME_LIMIT = (NAME_SPACE < 1024) ? NAME_SPACE : 1024;
  localparam int ROWS       = (NAME_LIMIT + NPR - 1) / NPR;
  localparam int RW         = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [RW-1:0]      LAST_ROW = RW'(ROWS - 1);
  localparam logic [CNT_W+1:0]   MG       = (CNT_W + 2)'(MAX_GEN);
  localparam logic [NAME_W:0]    LIM      = (NAME_W + 1)'(NAME_LIMIT);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_LOAD = 6'b000100,
    S_WORK = 6'b001000,
    S_ONE  = 6'b010000,
    S_ERR  = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [RW-1:0]       row_r, row_nxt;
  logic [BIT_W-1:0]    bit_r, bit_nxt;
  logic                nvalid_r, nvalid_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [2*NPR-1:0]    row_data_r, row_data_nxt;
  logic [ROWS-1:0]     row_vld_r, row_vld_nxt;

  logic                out_valid_r;
  logic [NAME_W-1:0]   out_name_r;
  logic                out_is_created_r, out_status_r, out_last_r;

  logic                ram_we;
  logic [2*NPR-1:0]    ram_wdata, ram_rdata;
  logic [2*NPR-1:0]    row_mod;
  scan_res_t           scan;

  logic                slot_free, emit, e_cr, e_st, e_last;
  logic [NAME_W-1:0]   e_name;
  logic                in_nvalid;
  logic [CNT_W-1:0]    in_cnt_sat;

  ona_ram #(.WIDTH(2 * NPR), .DEPTH(ROWS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row_r),
    .wdata (ram_wdata),
    .raddr (row_r),
    .rdata (ram_rdata)
  );

  ona_scan #(.NAME_LIMIT(NAME_LIMIT), .RW(RW)) u_scan (
    .row (row_r),
    .rsv (row_data_r[NPR-1:0]),
    .res (scan)
  );

  assign in_stall   = (state_r != S_IDLE);
  assign slot_free  = !out_valid_r || !out_stall;
  assign in_nvalid  = (in_name != '0) && ({1'b0, in_name} < LIM);
  assign in_cnt_sat = ({2'b0, in_count} > MG) ? MG[CNT_W-1:0] : in_count;

  always_comb begin
    row_mod = row_data_r;
    if (op_r == OP_DEL) begin
      row_mod[{1'b0, bit_r}] = 1'b0;
      row_mod[{1'b1, bit_r}] = 1'b0;
    end else if (op_r == OP_BIND) begin
      row_mod[{1'b0, bit_r}] = 1'b1;
      row_mod[{1'b1, bit_r}] = 1'b1;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    row_nxt      = row_r;
    bit_nxt      = bit_r;
    nvalid_nxt   = nvalid_r;
    cnt_nxt      = cnt_r;
    row_data_nxt = row_data_r;
    row_vld_nxt  = row_vld_r;
    ram_we       = 1'b0;
    ram_wdata    = row_data_r;
    emit         = 1'b0;
    e_name       = '0;
    e_cr         = 1'b0;
    e_st         = 1'b0;
    e_last       = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = op_t'(in_opcode);
          nvalid_nxt = in_nvalid;
          bit_nxt    = in_name[BIT_W-1:0];
          cnt_nxt    = in_cnt_sat;
          if (op_t'(in_opcode) == OP_GEN) begin
            row_nxt   = '0;
            state_nxt = (in_cnt_sat == '0) ? S_IDLE : S_RD;
          end else begin
            row_nxt   = in_name[BIT_W +: RW];
            state_nxt = in_nvalid ? S_RD : S_ONE;
          end
        end
      end
      S_RD: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        row_data_nxt = row_vld_r[row_r] ? ram_rdata : '0;
        state_nxt    = (op_r == OP_GEN) ? S_WORK : S_ONE;
      end
      S_WORK: begin
        if (cnt_r == '0) begin
          ram_we    = 1'b1;
          state_nxt = S_IDLE;
        end else if (scan.found) begin
          if (slot_free) begin
            emit   = 1'b1;
            e_name = NAME_W'({row_r, scan.idx});
            e_last = (cnt_r == CNT_W'(1));
            row_data_nxt[{1'b0, scan.idx}] = 1'b1;
            row_data_nxt[{1'b1, scan.idx}] = 1'b0;
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end else begin
          ram_we = 1'b1;
          if (row_r == LAST_ROW) begin
            state_nxt = S_ERR;
          end else begin
            row_nxt   = row_r + RW'(1);
            state_nxt = S_RD;
          end
        end
      end
      S_ONE: begin
        if (slot_free) begin
          emit      = 1'b1;
          e_cr      = (op_r == OP_QUERY) && nvalid_r && row_data_r[{1'b0, bit_r}]
                      && row_data_r[{1'b1, bit_r}];
          ram_we    = nvalid_r && ((op_r == OP_DEL) || (op_r == OP_BIND));
          ram_wdata = row_mod;
          state_nxt = S_IDLE;
        end
      end
      S_ERR: begin
        if (slot_free) begin
          emit      = 1'b1;
          e_st      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (ram_we) begin
      row_vld_nxt[row_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      row_vld_r <= row_vld_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    row_r      <= row_nxt;
    bit_r      <= bit_nxt;
    nvalid_r   <= nvalid_nxt;
    cnt_r      <= cnt_nxt;
    row_data_r <= row_data_nxt;
    if (emit) begin
      out_name_r       <= e_name;
      out_is_created_r <= e_cr;
      out_status_r     <= e_st;
      out_last_r       <= e_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_name       = out_name_r;
  assign out_is_created = out_is_created_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;

endmodule
`default_nettype wire

/* rtl/ona_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ona_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [AW-1:0]          waddr,
  input  wire logic [WIDTH-1:0]       wdata,
  input  wire logic [AW-1:0]          raddr,
  output logic      [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* rtl/ona_scan.sv */
// Lowest free name search over one row of the reserved map.
`default_nettype none
module ona_scan import ona_pkg::*; #(
  parameter int NAME_LIMIT = 1024,
  parameter int RW         = 6
) (
  input  wire logic [RW-1:0]  row,
  input  wire logic [NPR-1:0] rsv,
  output scan_res_t           res
);
  localparam int NW = RW + BIT_W;
  localparam logic [NW:0] LIM = (NW + 1)'(NAME_LIMIT);

  always_comb begin
    logic [NW-1:0] nm;
    res = '0;
    nm  = '0;
    for (int b = NPR - 1; b >= 0; b--) begin
      nm = {row, BIT_W'(b)};
      if (!rsv[b] && (nm != '0) && ({1'b0, nm} < LIM)) begin
        res.found = 1'b1;
        res.idx   = BIT_W'(b);
      end
    end
  end

endmodule
`default_nettype wire
